[design/vertex_rotate_scale_translate_2d_core_macros.svh]
// Assertion macros for the vertex transform core.
// Included by the top level; no other dependencies.
`ifndef VERTEX_ROTATE_SCALE_TRANSLATE_2D_CORE_MACROS_SVH
`define VERTEX_ROTATE_SCALE_TRANSLATE_2D_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/vrst_pkg.sv]
// Types, constants and the arctangent table of the vertex transform core.
// No dependencies.
package vrst_pkg;

  localparam int XY_W       = 36;
  localparam int Z_W        = 34;
  localparam int ATAN_LEN   = 24;
  localparam int IN_SHIFT   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 2'd3;

  localparam logic signed [20:0] GAIN_COMP  = 21'sd636751;
  localparam int                 GAIN_SHIFT = 20;
  localparam int                 SCALE_SHIFT = 24;
  localparam logic signed [23:0] OUT_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN    = 24'sh800000;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
  } vertex_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [15:0]        rotation_angle;
    logic [15:0]        scale_factor;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  function automatic logic [31:0] atan_at(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[design/vrst_cordic_cell.sv]
// One CORDIC rotation stage with its own valid bit and backpressure.
// Depends on vrst_pkg.
module vrst_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  vrst_pkg::rot_t data_in,
  output logic           ready,
  output logic           valid_out,
  output vrst_pkg::rot_t data_out,
  input  logic           ready_next
);
  import vrst_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_at(STAGE));

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  rot_t                   data_next;

  assign dx    = $signed(data_in.y) >>> STAGE;
  assign dy    = $signed(data_in.x) >>> STAGE;
  assign ready = !valid_out || ready_next;

  always_comb begin
    if (!data_in.z[Z_W-1]) begin
      data_next.x = data_in.x - dx;
      data_next.y = data_in.y + dy;
      data_next.z = data_in.z - ATAN;
    end else begin
      data_next.x = data_in.x + dx;
      data_next.y = data_in.y - dy;
      data_next.z = data_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_in) begin
      data_out <= data_next;
    end
  end

endmodule

[design/vrst_post.sv]
// Gain compensation, scaling, rounding, translation and saturation pipeline.
// Depends on vrst_pkg.
module vrst_post (
  input  logic              clk,
  input  logic              rst,
  input  vrst_pkg::cfg_t    cfg,
  input  logic              valid_in,
  input  vrst_pkg::rot_t    data_in,
  output logic              ready,
  output logic              res_valid,
  output vrst_pkg::result_t res,
  input  logic              res_stall
);
  import vrst_pkg::*;

  localparam int P1_W = XY_W + 21;
  localparam int G_W  = 34;
  localparam int P3_W = G_W + 17;
  localparam int R_W  = 27;
  localparam int T_W  = R_W + 1;

  localparam logic signed [P1_W-1:0] RND1 = P1_W'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [P3_W-1:0] RND3 = P3_W'(1) <<< (SCALE_SHIFT - 1);
  localparam logic signed [T_W-1:0]  T_MAX = T_W'(OUT_MAX);
  localparam logic signed [T_W-1:0]  T_MIN = T_W'(OUT_MIN);

  logic [3:0] v;
  logic [4:0] rdy;

  logic signed [P1_W-1:0] px, py;
  logic signed [P1_W-1:0] px_r, py_r;
  logic signed [P1_W-1:0] m1x, m1y;
  logic signed [G_W-1:0]  gx, gy;
  logic signed [P3_W-1:0] sx, sy;
  logic signed [P3_W-1:0] sx_r, sy_r;
  logic signed [P3_W-1:0] sx_hold, sy_hold;
  logic signed [R_W-1:0]  rx, ry;
  logic signed [T_W-1:0]  tx, ty;
  result_t                res_next;

  assign rdy[4] = !res_valid || !res_stall;
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign ready  = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= valid_in;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) res_valid <= v[3];
    end
  end

  assign px   = P1_W'($signed(data_in.x)) * P1_W'(GAIN_COMP);
  assign py   = P1_W'($signed(data_in.y)) * P1_W'(GAIN_COMP);
  assign px_r = px + RND1;
  assign py_r = py + RND1;
  assign sx   = P3_W'(gx) * $signed({1'b0, cfg.scale_factor});
  assign sy   = P3_W'(gy) * $signed({1'b0, cfg.scale_factor});
  assign sx_r = sx + RND3;
  assign sy_r = sy + RND3;
  assign tx   = T_W'(rx) + T_W'(cfg.offset_x);
  assign ty   = T_W'(ry) + T_W'(cfg.offset_y);

  always_comb begin
    res_next.saturated = 1'b0;
    priority if (tx > T_MAX) begin
      res_next.out_x     = OUT_MAX;
      res_next.saturated = 1'b1;
    end else if (tx < T_MIN) begin
      res_next.out_x     = OUT_MIN;
      res_next.saturated = 1'b1;
    end else begin
      res_next.out_x = tx[23:0];
    end
    priority if (ty > T_MAX) begin
      res_next.out_y     = OUT_MAX;
      res_next.saturated = 1'b1;
    end else if (ty < T_MIN) begin
      res_next.out_y     = OUT_MIN;
      res_next.saturated = 1'b1;
    end else begin
      res_next.out_y = ty[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && valid_in) begin
      m1x <= px_r;
      m1y <= py_r;
    end
    if (rdy[1] && v[0]) begin
      gx <= m1x[GAIN_SHIFT+G_W-1:GAIN_SHIFT];
      gy <= m1y[GAIN_SHIFT+G_W-1:GAIN_SHIFT];
    end
    if (rdy[2] && v[1]) begin
      sx_hold <= sx_r;
      sy_hold <= sy_r;
    end
    if (rdy[3] && v[2]) begin
      rx <= sx_hold[SCALE_SHIFT+R_W-1:SCALE_SHIFT];
      ry <= sy_hold[SCALE_SHIFT+R_W-1:SCALE_SHIFT];
    end
    if (rdy[4] && v[3]) begin
      res <= res_next;
    end
  end

endmodule

[design/vertex_rotate_scale_translate_2d_core.sv]
// Pipeline: one quadrant stage, one cell per CORDIC stage (ROTATION_STAGES, capped at ATAN_LEN),
// five post stages (gain, gain round, scale, scale round, add and saturate).
// Throughput: one vertex per cycle while res_stall is low; each stage holds one vertex and advances
// whenever the next stage is empty or moving, so bubbles collapse under output stall.
// Reset: clears all valid bits and loads angle 0, scale 1.0 and offsets 100.0.
// Depends on vrst_pkg, vrst_cordic_cell, vrst_post and the assertion macro header.
module vertex_rotate_scale_translate_2d_core #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [vrst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vrst_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              vtx_valid,
  output logic                              vtx_stall,
  input  vrst_pkg::vertex_t                 vtx,
  output logic                              res_valid,
  input  logic                              res_stall,
  output vrst_pkg::result_t                 res
);
  import vrst_pkg::*;

  localparam int NUM_STAGES = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation_angle <= 16'd0;
      cfg.scale_factor   <= 16'd256;
      cfg.offset_x       <= 24'sd25600;
      cfg.offset_y       <= 24'sd25600;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROTATION_ANGLE: cfg.rotation_angle <= cfg_data[15:0];
        REG_SCALE_FACTOR:   cfg.scale_factor   <= cfg_data[15:0];
        REG_OFFSET_X:       cfg.offset_x       <= cfg_data[23:0];
        REG_OFFSET_Y:       cfg.offset_y       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [16:0]        angle_sum;
  logic [1:0]         quad;
  logic [15:0]        resid;
  logic signed [16:0] vx;
  logic signed [16:0] vy;
  logic signed [16:0] rx;
  logic signed [16:0] ry;
  rot_t               pre_next;
  logic               pre_ready;

  rot_t chain_data  [NUM_STAGES+1];
  logic chain_valid [NUM_STAGES+1];
  logic chain_ready [NUM_STAGES+1];

  assign angle_sum = {1'b0, cfg.rotation_angle} + 17'd8192;
  assign quad      = angle_sum[15:14];
  assign resid     = cfg.rotation_angle - {quad, 14'd0};
  assign vx        = 17'(vtx.vertex_x);
  assign vy        = 17'(vtx.vertex_y);

  always_comb begin
    unique case (quad)
      QUAD_0: begin
        rx = vx;
        ry = vy;
      end
      QUAD_90: begin
        rx = -vy;
        ry = vx;
      end
      QUAD_180: begin
        rx = -vx;
        ry = -vy;
      end
      QUAD_270: begin
        rx = vy;
        ry = -vx;
      end
      default: begin
        rx = vx;
        ry = vy;
      end
    endcase
    pre_next.x = XY_W'(rx) <<< IN_SHIFT;
    pre_next.y = XY_W'(ry) <<< IN_SHIFT;
    pre_next.z = Z_W'($signed(resid)) <<< IN_SHIFT;
  end

  assign pre_ready = !chain_valid[0] || chain_ready[0];
  assign vtx_stall = !pre_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (pre_ready) begin
      chain_valid[0] <= vtx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_ready && vtx_valid) begin
      chain_data[0] <= pre_next;
    end
  end

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    vrst_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (chain_valid[k]),
      .data_in   (chain_data[k]),
      .ready     (chain_ready[k]),
      .valid_out (chain_valid[k+1]),
      .data_out  (chain_data[k+1]),
      .ready_next(chain_ready[k+1])
    );
  end

  vrst_post u_post (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .valid_in (chain_valid[NUM_STAGES]),
    .data_in  (chain_data[NUM_STAGES]),
    .ready    (chain_ready[NUM_STAGES]),
    .res_valid(res_valid),
    .res      (res),
    .res_stall(res_stall)
  );

`include "vertex_rotate_scale_translate_2d_core_macros.svh"

  `VRST_ASSERT_SAME(a_empty_output_accepts, clk, rst, !res_valid, !vtx_stall, "stall with empty output")
  `VRST_ASSERT_NEXT(a_accept_loads_pre, clk, rst, vtx_valid && !vtx_stall, chain_valid[0], "vertex lost at entry")
  `VRST_ASSERT_SAME(a_sat_at_rail, clk, rst, res_valid && res.saturated, res.out_x == OUT_MAX || res.out_x == OUT_MIN || res.out_y == OUT_MAX || res.out_y == OUT_MIN, "saturated flag without clamped coordinate")

endmodule

[tb/testbench.sv]
// Self-checking testbench for vertex_rotate_scale_translate_2d_core: directed table, then
// randomized phases checked against a fixed-point CORDIC predictor with random stalls.
// Depends on vrst_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vrst_pkg::*;

  localparam int CORDIC_STAGES  = 16;
  localparam int PIPE_LATENCY   = CORDIC_STAGES + 6;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_AT_RESULT = 700;
  localparam int HOLD_CYCLES    = 120;
  localparam int IDLE_LIMIT     = 4000;
  localparam int MAX_REPORTS    = 10;

  // atan(2^-i) in 2^32-per-turn units, entry i at bits [i*32 +: 32]
  localparam logic [24*32-1:0] CORDIC_ANGLES = {
    32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
    32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  localparam result_t NO_RESULT = '0;

  typedef struct {
    cfg_t    setting;
    vertex_t v;
    bit      known;
    result_t want;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  vtx_valid = 1'b0;
  logic                  vtx_stall;
  vertex_t               vtx = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res;

  cfg_t          active_cfg;
  result_t       pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;
  int            rx_wait = 0;
  int            hold_left = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;

  vertex_rotate_scale_translate_2d_core #(
    .ROTATION_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic signed [23:0] clamp_q16(longint v, inout bit sat);
    if (v > longint'(OUT_MAX)) begin
      sat = 1'b1;
      return OUT_MAX;
    end
    if (v < longint'(OUT_MIN)) begin
      sat = 1'b1;
      return OUT_MIN;
    end
    return 24'(v);
  endfunction

  function automatic result_t transform_vertex(vertex_t v, cfg_t c);
    longint  px, py, swap, x, y, z, dx, dy, resid;
    int      quadrant, i;
    bit      sat;
    result_t r;
    quadrant = ((int'(c.rotation_angle) + 8192) >> 14) % 4;
    resid = longint'(c.rotation_angle) - quadrant * 16384;
    if (resid >= 32768) resid -= 65536;
    px = v.vertex_x;
    py = v.vertex_y;
    case (quadrant)
      1: begin
        swap = px; px = -py; py = swap;
      end
      2: begin
        px = -px; py = -py;
      end
      3: begin
        swap = px; px = py; py = -swap;
      end
      default: ;
    endcase
    x = px * 65536;
    y = py * 65536;
    z = resid * 65536;
    for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(CORDIC_ANGLES[i*32 +: 32]);
      end else begin
        x += dx; y -= dy; z += longint'(CORDIC_ANGLES[i*32 +: 32]);
      end
    end
    x = (x * longint'(GAIN_COMP) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    y = (y * longint'(GAIN_COMP) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    x = (x * longint'(c.scale_factor) + (longint'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    y = (y * longint'(c.scale_factor) + (longint'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    sat = 1'b0;
    r.out_x = clamp_q16(x + longint'(c.offset_x), sat);
    r.out_y = clamp_q16(y + longint'(c.offset_y), sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic cfg_t make_setting(int angle, int scale, int ox, int oy);
    cfg_t s;
    s.rotation_angle = 16'(angle);
    s.scale_factor   = 16'(scale);
    s.offset_x       = 24'(ox);
    s.offset_y       = 24'(oy);
    return s;
  endfunction

  function automatic logic signed [23:0] draw_offset();
    case ($urandom_range(0, 4))
      0: return OUT_MAX;
      1: return OUT_MIN;
      2: return 24'(int'($urandom_range(0, 200000)) - 100000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic cfg_t draw_setting();
    cfg_t s;
    case ($urandom_range(0, 3))
      0: s.rotation_angle = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
      1: s.rotation_angle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: s.rotation_angle = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: s.scale_factor = 16'h0000;
      1: s.scale_factor = 16'h0100;
      2: s.scale_factor = 16'hFFFF;
      3: s.scale_factor = 16'($urandom_range(0, 1024));
      default: s.scale_factor = 16'($urandom);
    endcase
    s.offset_x = draw_offset();
    s.offset_y = draw_offset();
    return s;
  endfunction

  function automatic logic signed [15:0] draw_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 1024)) - 512);
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_row(cfg_t s, int x, int y, bit known, result_t want);
    directed_row_t row;
    row.setting = s;
    row.v.vertex_x = 16'(x);
    row.v.vertex_y = 16'(y);
    row.known = known;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(REG_ROTATION_ANGLE, {8'($urandom), s.rotation_angle});
    write_reg(REG_SCALE_FACTOR, {8'($urandom), s.scale_factor});
    write_reg(REG_OFFSET_X, s.offset_x);
    write_reg(REG_OFFSET_Y, s.offset_y);
    active_cfg = s;
  endtask

  task automatic wait_idle();
    vtx_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic send_vertex(vertex_t v, bit known, result_t want);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      vtx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx = v;
    vtx_valid = 1'b1;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    pending_results.push_back(known ? want : transform_vertex(v, active_cfg));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      res_stall = 1'b0;
    end else if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else if (rx_wait > 0) begin
      res_stall = 1'b1;
      rx_wait--;
    end else begin
      res_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: x=%0d y=%0d sat=%0b",
                               res.out_x, res.out_y, res.saturated));
      end else begin
        want = pending_results.pop_front();
        if (res.out_x !== want.out_x || res.out_y !== want.out_y ||
            res.saturated !== want.saturated) begin
          note_failure($sformatf("mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                                 want.out_x, want.out_y, want.saturated,
                                 res.out_x, res.out_y, res.saturated));
        end
      end
      results_seen++;
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      else rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst || (vtx_valid && !vtx_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    cfg_t rs;
    rs = make_setting(0, 256, 25600, 25600);
    active_cfg = rs;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(rs, 0, 0, 1'b1, '{24'sd25600, 24'sd25600, 1'b0});
    add_row(rs, 32767, 32767, 1'b0, NO_RESULT);
    add_row(rs, -32768, -32768, 1'b0, NO_RESULT);
    add_row(rs, -32768, 32767, 1'b0, NO_RESULT);
    add_row(rs, 32767, -32768, 1'b0, NO_RESULT);
    add_row(rs, 256, -256, 1'b0, NO_RESULT);
    add_row(make_setting(16384, 256, 0, 0), 256, 0, 1'b0, NO_RESULT);
    add_row(make_setting(16384, 256, 0, 0), 0, 256, 1'b0, NO_RESULT);
    add_row(make_setting(8192, 256, 0, 0), 256, 256, 1'b0, NO_RESULT);
    add_row(make_setting(8191, 256, 0, 0), 256, 256, 1'b0, NO_RESULT);
    add_row(make_setting(32768, 256, 0, 0), -32768, 32767, 1'b0, NO_RESULT);
    add_row(make_setting(49152, 256, 0, 0), 32767, -32768, 1'b0, NO_RESULT);
    add_row(make_setting(57344, 256, 0, 0), 1000, -1000, 1'b0, NO_RESULT);
    add_row(make_setting(65535, 65535, 0, 0), 32767, 32767, 1'b0, NO_RESULT);
    add_row(make_setting(12345, 0, 8388607, -8388608), 32767, -32768, 1'b1,
            '{OUT_MAX, OUT_MIN, 1'b0});
    add_row(make_setting(12345, 0, 8388607, -8388608), -32768, 0, 1'b1,
            '{OUT_MAX, OUT_MIN, 1'b0});
    add_row(make_setting(0, 65535, 8388607, 8388607), 32767, 32767, 1'b1,
            '{OUT_MAX, OUT_MAX, 1'b1});
    add_row(make_setting(0, 65535, -8388608, -8388608), -32768, -32768, 1'b1,
            '{OUT_MIN, OUT_MIN, 1'b1});
    add_row(make_setting(0, 65535, 8388607, -8388608), 32767, -32768, 1'b1,
            '{OUT_MAX, OUT_MIN, 1'b1});
    add_row(make_setting(0, 65535, 8388607, 0), 32767, 0, 1'b0, NO_RESULT);
    add_row(make_setting(0, 65535, 8388607, 0), -1, -1, 1'b0, NO_RESULT);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].setting != active_cfg) begin
        wait_idle();
        apply_setting(directed_rows[n].setting);
      end
      send_vertex(directed_rows[n].v, directed_rows[n].known, directed_rows[n].want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      apply_setting(draw_setting());
      repeat (PHASE_ITEMS) begin
        vertex_t v;
        v.vertex_x = draw_coord();
        v.vertex_y = draw_coord();
        send_vertex(v, 1'b0, NO_RESULT);
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[vertex_rotate_scale_translate_2d_core.f]
+incdir+design
design/vrst_pkg.sv
design/vrst_cordic_cell.sv
design/vrst_post.sv
design/vertex_rotate_scale_translate_2d_core.sv
tb/testbench.sv
